[rtl/are_pkg.sv]
// Shared types and constants for the attack/release envelope block.
`default_nettype none
package are_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 24;
	localparam int LVL_W       = FRAC_BITS + 1;
	localparam int COEF_W      = 32;
	localparam int CFG_W       = 32;

	// shared multiplier: a takes the level or the sample, b a coefficient or the level
	localparam int MUL_A_W = ((SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W) + 1;
	localparam int MUL_B_W = COEF_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int HI_W    = PROD_W - FRAC_BITS;

	localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1) << FRAC_BITS;
	localparam logic [LVL_W-1:0] LVL_ZERO = '0;

	// register indexes
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_ATTACK  = 2'd1;
	localparam logic [1:0] REG_RELEASE = 2'd2;
	localparam logic [1:0] REG_START   = 2'd3;

	// modes
	localparam logic [1:0] MODE_LIN    = 2'd0;
	localparam logic [1:0] MODE_EXP    = 2'd1;
	localparam logic [1:0] MODE_EXP_AO = 2'd2;

	// envelope phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_ATTACK  = 2'd1;
	localparam logic [1:0] PH_HOLD    = 2'd2;
	localparam logic [1:0] PH_RELEASE = 2'd3;

	// register reset values
	localparam logic [1:0]        RST_MODE    = MODE_LIN;
	localparam logic [COEF_W-1:0] RST_ATTACK  = COEF_W'(1) << FRAC_BITS;
	localparam logic [LVL_W-1:0]  RST_RELEASE = LVL_ONE;
	localparam logic [LVL_W-1:0]  RST_START   = LVL_W'(16777);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          gate;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [1:0]                    phase;
	} out_word_t;

endpackage
`default_nettype wire

[rtl/attack_release_envelope.sv]
// Attack/hold/release envelope generator with one shared multiplier.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+--------------------------
//  smp      | in        | smp_valid/smp_stall| sample_in, gate
//  res      | out       | res_valid/res_stall| sample_out, phase
//  cfg      | in        | cfg_we             | cfg_index, cfg_data
//
// The accepting cycle steps the envelope (in the exponential modes level times
// coefficient on the multiplier, in linear mode an add or a subtract), then the
// scaling state scales the sample by the new level on the same multiplier. The
// scaling state waits while a result is held by res_stall. Reset clears phase,
// level and the result valid flag and loads the registers with their defaults.
`default_nettype none
module attack_release_envelope (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               smp_valid,
	output logic                    smp_stall,
	input  wire are_pkg::in_word_t  smp_word,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output are_pkg::out_word_t      res_word,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [are_pkg::CFG_W-1:0] cfg_data
);

	localparam int SB  = are_pkg::SAMPLE_BITS;
	localparam int FB  = are_pkg::FRAC_BITS;
	localparam int LW  = are_pkg::LVL_W;
	localparam int CW  = are_pkg::COEF_W;
	localparam int AW  = are_pkg::MUL_A_W;
	localparam int BW  = are_pkg::MUL_B_W;
	localparam int PW  = are_pkg::PROD_W;
	localparam int HW  = are_pkg::HI_W;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SCALE = 1'b1;

	localparam logic [CW:0]   LIN_ONE = {{(CW+1-LW){1'b0}}, are_pkg::LVL_ONE};
	localparam logic [HW-1:0] HI_ONE  = {{(HW-LW){1'b0}}, are_pkg::LVL_ONE};

	logic [1:0]    mode_q;
	logic [CW-1:0] attack_q;
	logic [LW-1:0] release_q;
	logic [LW-1:0] start_q;

	logic          state_q;
	logic [1:0]    phase_q;
	logic [LW-1:0] level_q;
	logic [SB-1:0] sample_q;

	logic                 res_valid_q;
	are_pkg::out_word_t   res_word_q;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic [HW-1:0]        prod_hi;

	logic [CW:0]   lin_sum;
	logic [LW-1:0] rel_sat;
	logic [LW-1:0] seed;
	logic          is_exp;
	logic          is_ao;
	logic [1:0]    phase_d;
	logic [LW-1:0] level_d;
	logic          accept;
	logic          emit;

	assign accept    = smp_valid && (state_q == ST_IDLE);
	assign emit      = (state_q == ST_SCALE) && (!res_valid_q || !res_stall);
	assign smp_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// shared multiplier
	always_comb begin
		if (state_q == ST_SCALE) begin
			mul_a = $signed({{(AW-SB){sample_q[SB-1]}}, sample_q});
			mul_b = $signed({{(BW-LW){1'b0}}, level_q});
		end else begin
			mul_a = $signed({{(AW-LW){1'b0}}, level_q});
			if (phase_q == are_pkg::PH_RELEASE)
				mul_b = $signed({{(BW-LW){1'b0}}, release_q});
			else
				mul_b = $signed({1'b0, attack_q});
		end
	end

	assign prod    = mul_a * mul_b;
	assign prod_hi = prod[PW-1:FB];

	assign lin_sum = {{(CW+1-LW){1'b0}}, level_q} + {1'b0, attack_q};
	assign rel_sat = (prod_hi > HI_ONE) ? are_pkg::LVL_ONE : prod_hi[LW-1:0];
	assign seed    = (start_q > are_pkg::LVL_ONE) ? are_pkg::LVL_ONE : start_q;
	assign is_exp  = (mode_q == are_pkg::MODE_EXP) || (mode_q == are_pkg::MODE_EXP_AO);
	assign is_ao   = (mode_q == are_pkg::MODE_EXP_AO);

	// envelope step
	always_comb begin
		phase_d = phase_q;
		level_d = level_q;
		if (!is_exp) begin
			case (phase_q)
				are_pkg::PH_ATTACK: begin
					if (lin_sum >= LIN_ONE) begin
						level_d = are_pkg::LVL_ONE;
						phase_d = are_pkg::PH_HOLD;
					end else begin
						level_d = lin_sum[LW-1:0];
					end
				end
				are_pkg::PH_HOLD: begin
					level_d = are_pkg::LVL_ONE;
					if (!smp_word.gate)
						phase_d = are_pkg::PH_RELEASE;
				end
				are_pkg::PH_RELEASE: begin
					if (release_q >= level_q) begin
						level_d = are_pkg::LVL_ZERO;
						phase_d = are_pkg::PH_IDLE;
					end else begin
						level_d = level_q - release_q;
					end
				end
				default: begin
					level_d = are_pkg::LVL_ZERO;
					if (smp_word.gate)
						phase_d = are_pkg::PH_ATTACK;
				end
			endcase
		end else if (phase_q == are_pkg::PH_ATTACK) begin
			if (prod_hi >= HI_ONE) begin
				level_d = are_pkg::LVL_ONE;
				phase_d = is_ao ? are_pkg::PH_IDLE : are_pkg::PH_HOLD;
			end else begin
				level_d = prod_hi[LW-1:0];
			end
		end else if (phase_q == are_pkg::PH_HOLD && !is_ao) begin
			level_d = are_pkg::LVL_ONE;
			if (!smp_word.gate)
				phase_d = are_pkg::PH_RELEASE;
		end else if (phase_q == are_pkg::PH_RELEASE && !is_ao) begin
			if (rel_sat <= start_q) begin
				level_d = are_pkg::LVL_ZERO;
				phase_d = are_pkg::PH_IDLE;
			end else begin
				level_d = rel_sat;
			end
		end else begin
			// idle, or hold/release left over after a switch to attack-only
			phase_d = are_pkg::PH_IDLE;
			level_d = is_ao ? are_pkg::LVL_ONE : are_pkg::LVL_ZERO;
			if (smp_word.gate) begin
				level_d = seed;
				phase_d = are_pkg::PH_ATTACK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= are_pkg::RST_MODE;
			attack_q  <= are_pkg::RST_ATTACK;
			release_q <= are_pkg::RST_RELEASE;
			start_q   <= are_pkg::RST_START;
		end else if (cfg_we) begin
			case (cfg_index)
				are_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
				are_pkg::REG_ATTACK:  attack_q  <= cfg_data[CW-1:0];
				are_pkg::REG_RELEASE: release_q <= cfg_data[LW-1:0];
				are_pkg::REG_START:   start_q   <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= are_pkg::PH_IDLE;
			level_q     <= are_pkg::LVL_ZERO;
			res_valid_q <= 1'b0;
		end else begin
			if (emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= phase_d;
						level_q <= level_d;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= smp_word.sample_in;
		if (emit) begin
			res_word_q.sample_out <= prod[FB +: SB];
			res_word_q.phase      <= phase_q;
		end
	end

endmodule
`default_nettype wire

[rtl/are_checker.sv]
// Port-level checks for the envelope block, bound to its top level.
`default_nettype none
module are_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               smp_valid,
	input wire logic               smp_stall,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire are_pkg::out_word_t res_word
);

	// a held result keeps its word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// a word is still in work in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp_stall |=> smp_stall)
		else $error("input taken again straight after an accept");

	// a fresh result only comes out of the scaling cycle
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(smp_stall))
		else $error("result raised without a word in work");

	// a result is never raised straight after an accept, while its word is still to be scaled
	a_res_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(smp_valid && !smp_stall))
		else $error("result raised in the cycle after an accept");

endmodule

bind attack_release_envelope are_checker u_are_checker (.*);
`default_nettype wire
